// File: sv/kclp_pkg.sv
// ----------------------------------------------------------------------------
// kclp_pkg
// Shared types and constants for the key click / long-press detector:
// slot word layout, detector state record and result record.
// ----------------------------------------------------------------------------
`default_nettype none

package kclp_pkg;

    // Number of key slots that are searched and stored
    localparam int KEY_SLOTS   = 4;
    localparam int SLOT_IDX_W  = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int SLOT_W      = 45;
    localparam int KEY_W       = 8;
    localparam int TIME_W      = 32;
    localparam int DUR_W       = 16;

    // Slot word bit positions
    localparam int SW_VALID    = 44;
    localparam int SW_VAL_LO   = 36;
    localparam int SW_GAP_LO   = 20;
    localparam int SW_HOLD_LO  = 4;
    localparam int SW_EN_SGL   = 3;
    localparam int SW_EN_DBL   = 2;
    localparam int SW_EN_LNG   = 1;
    localparam int SW_EN_UP    = 0;

    typedef logic [SLOT_W-1:0]     t_slot_word;
    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;
    typedef logic [KEY_W-1:0]      t_keys;
    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [DUR_W-1:0]      t_dur;

    // Detector state carried from one tick to the next
    typedef struct packed {
        t_keys     previous_keys;
        t_time     first_press_time;
        t_keys     first_key;
        t_keys     second_key;
        logic      record_valid;
        t_slot_idx record_slot;
        logic      release_pending;
        t_slot_idx release_slot;
        logic      hold_flag;
    } t_state;

    // Detector state after reset: everything clear, hold flag set
    localparam t_state STATE_RESET = '{
        previous_keys:    '0,
        first_press_time: '0,
        first_key:        '0,
        second_key:       '0,
        record_valid:     1'b0,
        record_slot:      '0,
        release_pending:  1'b0,
        release_slot:     '0,
        hold_flag:        1'b1
    };

    // One result beat
    typedef struct packed {
        logic      single_fired;
        logic      double_fired;
        logic      long_fired;
        logic      up_fired;
        t_slot_idx event_slot;
        t_slot_idx up_slot;
    } t_result;

endpackage

`default_nettype wire

// File: sv/kclp_intf.sv
// ----------------------------------------------------------------------------
// kclp_intf
// Valid/ready channels of the detector: key samples in, events out.
// ----------------------------------------------------------------------------
`default_nettype none

interface kclp_key_if;
    logic                valid;
    logic                ready;
    kclp_pkg::t_keys     key_state;
    kclp_pkg::t_time     now_ms;

    modport source (output valid, output key_state, output now_ms, input ready);
    modport sink   (input valid, input key_state, input now_ms, output ready);
endinterface

interface kclp_evt_if;
    logic                  valid;
    logic                  ready;
    logic                  single_fired;
    logic                  double_fired;
    logic                  long_fired;
    logic                  up_fired;
    kclp_pkg::t_slot_idx   event_slot;
    kclp_pkg::t_slot_idx   up_slot;

    modport source (output valid, output single_fired, output double_fired,
                    output long_fired, output up_fired, output event_slot,
                    output up_slot, input ready);
    modport sink   (input valid, input single_fired, input double_fired,
                    input long_fired, input up_fired, input event_slot,
                    input up_slot, output ready);
endinterface

`default_nettype wire

// File: sv/key_click_long_press_detector_core.sv
// ----------------------------------------------------------------------------
// key_click_long_press_detector_core
// Key click / long-press detector with valid/ready channels.
//
// Each beat on i_key carries one sample: the key vector and the current
// millisecond time. For every accepted sample the block returns exactly one
// beat on o_evt with the single, double, long and release flags and their
// slot numbers.
// A sample accepted on i_key is held in the input register; the tick logic
// then writes the detector state and the result register once the result
// register is free or drained.
// Throughput: one sample per cycle unless o_evt stalls; the detector state
// is updated once per sample as it moves from the input register to the
// result register. When o_evt stalls, the result register holds and the
// input register fills; i_key.ready drops only when both are full.
// The user must write slot registers through i_cfg_we / i_cfg_idx /
// i_cfg_data only while no sample is in flight; the block does not enforce
// this. Reset clears slots, state (hold flag set) and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module key_click_long_press_detector_core (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [kclp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [kclp_pkg::SLOT_W-1:0]         i_cfg_data,
    kclp_key_if.sink                           i_key,
    kclp_evt_if.source                         o_evt
);

    kclp_pkg::t_slot_word r_slot [kclp_pkg::KEY_SLOTS];
    kclp_pkg::t_state     r_state;
    kclp_pkg::t_state     n_state;
    kclp_pkg::t_result    n_res;
    kclp_pkg::t_result    r_res;
    logic                 r_in_valid;
    kclp_pkg::t_keys      r_ks;
    kclp_pkg::t_time      r_now;
    logic                 r_out_valid;
    logic                 adv;
    logic                 take;

    // Move the sample forward when the result register is free or drained
    assign adv  = r_in_valid && (!r_out_valid || o_evt.ready);
    assign take = i_key.valid && i_key.ready;
    assign i_key.ready = !r_in_valid || adv;

    // Hold slot configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kclp_pkg::KEY_SLOTS; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_cfg_we && (int'(i_cfg_idx) < kclp_pkg::KEY_SLOTS)) begin
            r_slot[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ks  <= i_key.key_state;
            r_now <= i_key.now_ms;
        end
    end

    kclp_step u_step (
        .i_key_state (r_ks),
        .i_now_ms    (r_now),
        .i_state     (r_state),
        .i_slots     (r_slot),
        .o_state     (n_state),
        .o_result    (n_res)
    );

    // Advance detector state once per sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kclp_pkg::STATE_RESET;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_evt.valid        = r_out_valid;
    assign o_evt.single_fired = r_res.single_fired;
    assign o_evt.double_fired = r_res.double_fired;
    assign o_evt.long_fired   = r_res.long_fired;
    assign o_evt.up_fired     = r_res.up_fired;
    assign o_evt.event_slot   = r_res.event_slot;
    assign o_evt.up_slot      = r_res.up_slot;

    // A tick reports at most one of single, double and long
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_res.single_fired, r_res.double_fired,
                                    r_res.long_fired}) <= 1)
        else $error("more than one click/long event in one beat");

    // Slot numbers read zero when their event did not fire
    a_idle_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.up_fired || r_res.up_slot == '0) &&
            (r_res.single_fired || r_res.double_fired || r_res.long_fired ||
             r_res.event_slot == '0)))
        else $error("slot number set without its event");

    // A release event disarms and clears its slot
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.release_pending |-> r_state.release_slot == '0)
        else $error("release slot held while not armed");

    // Every advanced sample lands in the result register
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("sample advanced without a result");

endmodule

`default_nettype wire

// File: sv/kclp_step.sv
// ----------------------------------------------------------------------------
// kclp_step
// One tick of the detector: edge detection, slot match, click and long-press
// timing, release event. Pure combinational next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module kclp_step (
    input  kclp_pkg::t_keys      i_key_state,
    input  kclp_pkg::t_time      i_now_ms,
    input  kclp_pkg::t_state     i_state,
    input  kclp_pkg::t_slot_word i_slots [kclp_pkg::KEY_SLOTS],
    output kclp_pkg::t_state     o_state,
    output kclp_pkg::t_result    o_result
);

    kclp_pkg::t_keys      chg;
    kclp_pkg::t_keys      down;
    kclp_pkg::t_keys      up;
    logic                 hit;
    kclp_pkg::t_slot_idx  hit_idx;

    // Find edges against the previous sample
    assign chg  = i_state.previous_keys ^ i_key_state;
    assign down = i_key_state & chg;
    assign up   = ~i_key_state & chg;

    // Pick the first valid slot whose key value equals the press vector
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = kclp_pkg::KEY_SLOTS - 1; i >= 0; i--) begin
            if (i_slots[i][kclp_pkg::SW_VALID] &&
                i_slots[i][kclp_pkg::SW_VAL_LO +: kclp_pkg::KEY_W] == down) begin
                hit     = 1'b1;
                hit_idx = kclp_pkg::SLOT_IDX_W'(i);
            end
        end
        if (down == '0) begin
            hit = 1'b0;
        end
    end

    // Update the press record, then run the click and long-press checks
    always_comb begin
        kclp_pkg::t_state     s;
        kclp_pkg::t_result    r;
        kclp_pkg::t_slot_word w;
        kclp_pkg::t_time      elapsed;
        logic                 click;

        s       = i_state;
        r       = '0;
        w       = '0;
        elapsed = '0;
        click   = 1'b0;

        s.previous_keys = i_key_state;

        if (hit) begin
            if (s.first_key == '0 && s.second_key == '0) begin
                s.first_press_time = i_now_ms;
                s.first_key        = down;
                s.record_valid     = 1'b1;
                s.record_slot      = hit_idx;
            end else if (s.first_key != '0 && s.second_key == '0) begin
                s.second_key   = down;
                s.record_valid = 1'b1;
                s.record_slot  = hit_idx;
            end
        end

        if (s.record_valid) begin
            w       = i_slots[s.record_slot];
            elapsed = i_now_ms - s.first_press_time;
            if (i_key_state == '0) begin
                s.hold_flag = 1'b0;
            end
            click = (s.first_key != '0) && !s.hold_flag &&
                    (elapsed > kclp_pkg::TIME_W'(w[kclp_pkg::SW_GAP_LO +: kclp_pkg::DUR_W]));
            if (click) begin
                // Report single or double; a mismatched second press drops silently
                if (s.second_key == '0) begin
                    if (w[kclp_pkg::SW_EN_SGL]) begin
                        r.single_fired = 1'b1;
                        r.event_slot   = s.record_slot;
                    end
                end else if (s.second_key == s.first_key) begin
                    if (w[kclp_pkg::SW_EN_DBL]) begin
                        r.double_fired = 1'b1;
                        r.event_slot   = s.record_slot;
                    end
                end
                s.record_valid = 1'b0;
                s.record_slot  = '0;
                s.first_key    = '0;
                s.second_key   = '0;
                s.hold_flag    = 1'b1;
            end else if (s.first_key != '0 && s.second_key == '0 &&
                         elapsed > kclp_pkg::TIME_W'(w[kclp_pkg::SW_HOLD_LO +: kclp_pkg::DUR_W]))
            begin
                // Long press: report and arm the release event
                if (w[kclp_pkg::SW_EN_LNG]) begin
                    r.long_fired = 1'b1;
                    r.event_slot = s.record_slot;
                end
                if (w[kclp_pkg::SW_EN_UP]) begin
                    s.release_pending = 1'b1;
                    s.release_slot    = s.record_slot;
                end
                s.record_valid = 1'b0;
                s.record_slot  = '0;
                s.first_key    = '0;
            end
        end

        // Fire the armed release event on any release edge
        if (up != '0 && s.release_pending) begin
            r.up_fired        = 1'b1;
            r.up_slot         = s.release_slot;
            s.hold_flag       = 1'b1;
            s.release_pending = 1'b0;
            s.release_slot    = '0;
        end

        o_state  = s;
        o_result = r;
    end

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key click / long-press detector core.
// A directed plan walks through single, double and long presses, the release
// event, time wrap, disabled events and same-tick corner cases. Random
// gestures and noise then run under several slot settings, including all
// zeros and all ones. Every result beat is checked against a local model of
// the detector, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kclp_pkg::*;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_SLOT_0,
        REG_KEY_SLOT_1,
        REG_KEY_SLOT_2,
        REG_KEY_SLOT_3
    } t_slot_reg;

    typedef struct {
        t_keys   keys;
        t_time   at;
        bit      typed;
        t_result want;
    } t_plan_row;

    localparam t_result QUIET       = '0;
    localparam int      IDLE_PCT    = 12;
    localparam int      SETTLE      = 4;
    localparam int      CYCLE_LIMIT = 200000;
    localparam int      PHASES      = 6;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [SLOT_W-1:0]    i_cfg_data;

    kclp_key_if key_if ();
    kclp_evt_if evt_if ();

    key_click_long_press_detector_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_key      (key_if),
        .o_evt      (evt_if)
    );

    // Model copy of the detector state and slot registers
    t_state     det;
    t_slot_word slot_cfg [KEY_SLOTS];
    t_slot_word next_cfg [KEY_SLOTS];

    t_result    expected_events [$];
    t_plan_row  plan [$];

    t_time      clock_ms;
    int         step_max;
    int         beats_sent;
    int         faults;
    int         reported;
    int         cycles;
    bit         calm;
    t_result    seen_evt;
    t_result    want_evt;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_slot_word slot_word(input bit valid, input t_keys value,
                                             input t_dur gap, input t_dur hold,
                                             input logic [3:0] en);
        t_slot_word w;
        w = '0;
        w[SW_VALID]             = valid;
        w[SW_VAL_LO +: KEY_W]   = value;
        w[SW_GAP_LO +: DUR_W]   = gap;
        w[SW_HOLD_LO +: DUR_W]  = hold;
        w[SW_EN_SGL]            = en[3];
        w[SW_EN_DBL]            = en[2];
        w[SW_EN_LNG]            = en[1];
        w[SW_EN_UP]             = en[0];
        return w;
    endfunction

    function automatic t_slot_word random_slot();
        t_keys v;
        if ($urandom_range(0, 3) == 0)
            v = t_keys'($urandom);
        else
            v = t_keys'(1) << $urandom_range(0, KEY_W - 1);
        return slot_word($urandom_range(0, 7) != 0, v, t_dur'($urandom_range(0, 150)),
                         t_dur'($urandom_range(0, 300)), 4'($urandom));
    endfunction

    function automatic t_result fired(input bit s, input bit d, input bit l, input bit u,
                                      input t_slot_idx es, input t_slot_idx us);
        t_result r;
        r.single_fired = s;
        r.double_fired = d;
        r.long_fired   = l;
        r.up_fired     = u;
        r.event_slot   = es;
        r.up_slot      = us;
        return r;
    endfunction

    function automatic t_plan_row plan_row(input t_keys keys, input t_time at,
                                           input bit typed, input t_result want);
        t_plan_row p;
        p.keys  = keys;
        p.at    = at;
        p.typed = typed;
        p.want  = want;
        return p;
    endfunction

    // Advance the detector by one tick and return the events it reports
    function automatic t_result tick_detector(input t_keys ks, input t_time now);
        t_keys      chg;
        t_keys      down;
        t_keys      up;
        t_slot_word w;
        t_time      elapsed;
        t_result    r;
        bit         hit;
        int         i;
        r    = QUIET;
        chg  = det.previous_keys ^ ks;
        down = ks & chg;
        up   = ~ks & chg;
        det.previous_keys = ks;

        // Match the press vector against the slots, first valid match wins
        hit = 1'b0;
        if (down != '0) begin
            for (i = 0; i < KEY_SLOTS; i++) begin
                w = slot_cfg[i];
                if (!hit && w[SW_VALID] && w[SW_VAL_LO +: KEY_W] == down) begin
                    hit = 1'b1;
                    if (det.first_key == '0 && det.second_key == '0) begin
                        det.first_press_time = now;
                        det.first_key        = down;
                        det.record_valid     = 1'b1;
                        det.record_slot      = t_slot_idx'(i);
                    end else if (det.first_key != '0 && det.second_key == '0) begin
                        det.second_key   = down;
                        det.record_valid = 1'b1;
                        det.record_slot  = t_slot_idx'(i);
                    end
                end
            end
        end

        if (det.record_valid) begin
            w       = slot_cfg[det.record_slot];
            elapsed = now - det.first_press_time;
            if (ks == '0)
                det.hold_flag = 1'b0;
            // Click check: released and gap expired
            if (det.first_key != '0 && !det.hold_flag &&
                elapsed > t_time'(w[SW_GAP_LO +: DUR_W])) begin
                if (det.second_key == '0) begin
                    if (w[SW_EN_SGL]) begin
                        r.single_fired = 1'b1;
                        r.event_slot   = det.record_slot;
                    end
                end else if (det.second_key == det.first_key) begin
                    if (w[SW_EN_DBL]) begin
                        r.double_fired = 1'b1;
                        r.event_slot   = det.record_slot;
                    end
                end
                det.record_valid = 1'b0;
                det.record_slot  = '0;
                det.first_key    = '0;
                det.second_key   = '0;
                det.hold_flag    = 1'b1;
            end
            // Long check: skipped once the click check cleared the record
            if (det.record_valid && det.first_key != '0 && det.second_key == '0 &&
                elapsed > t_time'(w[SW_HOLD_LO +: DUR_W])) begin
                if (w[SW_EN_LNG]) begin
                    r.long_fired = 1'b1;
                    r.event_slot = det.record_slot;
                end
                if (w[SW_EN_UP]) begin
                    det.release_pending = 1'b1;
                    det.release_slot    = det.record_slot;
                end
                det.record_valid = 1'b0;
                det.record_slot  = '0;
                det.first_key    = '0;
            end
        end

        // Release event fires on any release edge while armed
        if (up != '0 && det.release_pending) begin
            r.up_fired          = 1'b1;
            r.up_slot           = det.release_slot;
            det.hold_flag       = 1'b1;
            det.release_pending = 1'b0;
            det.release_slot    = '0;
        end
        return r;
    endfunction

    function automatic t_time advance_clock();
        clock_ms += t_time'($urandom_range(0, step_max));
        return clock_ms;
    endfunction

    // Send one sample beat, idling at random beforehand
    task automatic push_sample(input t_keys k, input t_time t, input bit typed,
                               input t_result want);
        t_result predicted;
        calm = (beats_sent >= 400 && beats_sent < 600);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            key_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        key_if.valid     <= 1'b1;
        key_if.key_state <= k;
        key_if.now_ms    <= t;
        @(posedge i_clk);
        while (!key_if.ready)
            @(posedge i_clk);
        predicted = tick_detector(k, t);
        expected_events.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // Hold off until every pending event beat has come back
    task automatic drain_events();
        key_if.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_slots();
        int i;
        for (i = 0; i < KEY_SLOTS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= t_slot_reg'(i);
            i_cfg_data <= next_cfg[i];
            @(posedge i_clk);
            slot_cfg[i] = next_cfg[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // Press, hold and release a slot's key one to three times, then send up to six released samples
    task automatic run_gesture();
        int    s;
        int    p;
        int    j;
        int    n;
        int    presses;
        t_keys first;
        t_keys k;
        s     = $urandom_range(0, KEY_SLOTS - 1);
        first = slot_cfg[s][SW_VAL_LO +: KEY_W];
        if (!slot_cfg[s][SW_VALID] || first == '0 || $urandom_range(0, 9) == 0)
            first = t_keys'(1) << $urandom_range(0, KEY_W - 1);
        presses = $urandom_range(1, 3);
        for (p = 0; p < presses; p++) begin
            k = first;
            if (p > 0 && $urandom_range(0, 4) == 0)
                k = slot_cfg[$urandom_range(0, KEY_SLOTS - 1)][SW_VAL_LO +: KEY_W];
            n = $urandom_range(1, 5);
            for (j = 0; j < n; j++)
                push_sample(k, advance_clock(), 1'b0, QUIET);
            n = $urandom_range(1, 3);
            for (j = 0; j < n; j++)
                push_sample('0, advance_clock(), 1'b0, QUIET);
        end
        n = $urandom_range(0, 6);
        for (j = 0; j < n; j++)
            push_sample('0, advance_clock(), 1'b0, QUIET);
    endtask

    // Random key vectors with occasional jumps anywhere in time
    task automatic run_noise();
        int j;
        int n;
        n = $urandom_range(1, 6);
        for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 7) == 0)
                clock_ms = t_time'($urandom);
            push_sample(t_keys'($urandom), advance_clock(), 1'b0, QUIET);
        end
    endtask

    // Result channel: stall at random and check each beat
    always @(posedge i_clk) begin
        evt_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            seen_evt = fired(evt_if.single_fired, evt_if.double_fired, evt_if.long_fired,
                             evt_if.up_fired, evt_if.event_slot, evt_if.up_slot);
            if (expected_events.size() == 0) begin
                faults++;
                if (reported < 10) begin
                    reported++;
                    $display("event beat with nothing pending: s%0b d%0b l%0b u%0b ev%0d up%0d",
                             seen_evt.single_fired, seen_evt.double_fired,
                             seen_evt.long_fired, seen_evt.up_fired,
                             seen_evt.event_slot, seen_evt.up_slot);
                end
            end else begin
                want_evt = expected_events.pop_front();
                if (seen_evt.single_fired !== want_evt.single_fired ||
                    seen_evt.double_fired !== want_evt.double_fired ||
                    seen_evt.long_fired   !== want_evt.long_fired   ||
                    seen_evt.up_fired     !== want_evt.up_fired     ||
                    seen_evt.event_slot   !== want_evt.event_slot   ||
                    seen_evt.up_slot      !== want_evt.up_slot) begin
                    faults++;
                    if (reported < 10) begin
                        reported++;
                        $display({"event mismatch: expected s%0b d%0b l%0b u%0b ev%0d up%0d,",
                                  " got s%0b d%0b l%0b u%0b ev%0d up%0d"},
                                 want_evt.single_fired, want_evt.double_fired,
                                 want_evt.long_fired, want_evt.up_fired,
                                 want_evt.event_slot, want_evt.up_slot,
                                 seen_evt.single_fired, seen_evt.double_fired,
                                 seen_evt.long_fired, seen_evt.up_fired,
                                 seen_evt.event_slot, seen_evt.up_slot);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int phase;
        int phase_start;
        int i;
        int phase_items [PHASES];

        phase_items = '{250, 80, 170, 250, 200, 200};
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= REG_KEY_SLOT_0;
        i_cfg_data       <= '0;
        key_if.valid     <= 1'b0;
        key_if.key_state <= '0;
        key_if.now_ms    <= '0;
        faults     = 0;
        reported   = 0;
        cycles     = 0;
        beats_sent = 0;
        calm       = 1'b0;
        step_max   = 60;
        det           = '0;
        det.hold_flag = 1'b1;
        for (i = 0; i < KEY_SLOTS; i++)
            slot_cfg[i] = '0;

        // Hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed slots: plain click key, zero-time key, extreme silent key, shadowed copy
        next_cfg[0] = slot_word(1'b1, 8'h01, 16'd100, 16'd500, 4'b1111);
        next_cfg[1] = slot_word(1'b1, 8'h02, 16'd0, 16'd0, 4'b1001);
        next_cfg[2] = slot_word(1'b1, 8'h80, 16'hFFFF, 16'hFFFF, 4'b0000);
        next_cfg[3] = slot_word(1'b1, 8'h02, 16'd5, 16'd5, 4'b1111);
        program_slots();

        plan.push_back(plan_row(8'h00, 32'd0, 1'b1, QUIET));
        // single click
        plan.push_back(plan_row(8'h01, 32'd10, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'd20, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'd111, 1'b1, fired(1, 0, 0, 0, 0, 0)));
        // double click
        plan.push_back(plan_row(8'h01, 32'd200, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'd210, 1'b0, QUIET));
        plan.push_back(plan_row(8'h01, 32'd220, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'd301, 1'b1, fired(0, 1, 0, 0, 0, 0)));
        // long press at the hold boundary, then its release
        plan.push_back(plan_row(8'h01, 32'd1000, 1'b0, QUIET));
        plan.push_back(plan_row(8'h01, 32'd1500, 1'b0, QUIET));
        plan.push_back(plan_row(8'h01, 32'd1501, 1'b1, fired(0, 0, 1, 0, 0, 0)));
        plan.push_back(plan_row(8'h00, 32'd1600, 1'b1, fired(0, 0, 0, 1, 0, 0)));
        // elapsed time across the wrap of the clock
        plan.push_back(plan_row(8'h01, 32'hFFFF_FFF0, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'hFFFF_FFF8, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'h0000_0054, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'h0000_0055, 1'b1, fired(1, 0, 0, 0, 0, 0)));
        // long with its report disabled still arms the release
        plan.push_back(plan_row(8'h02, 32'd2000, 1'b0, QUIET));
        plan.push_back(plan_row(8'h02, 32'd2001, 1'b1, QUIET));
        plan.push_back(plan_row(8'h00, 32'd2002, 1'b1, fired(0, 0, 0, 1, 0, 1)));
        // every event disabled: record clears silently past the widest gap
        plan.push_back(plan_row(8'h80, 32'd3000, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'd3001, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'd68536, 1'b1, QUIET));
        // press vector with no matching slot
        plan.push_back(plan_row(8'h03, 32'd70000, 1'b1, QUIET));
        plan.push_back(plan_row(8'h00, 32'd70001, 1'b0, QUIET));
        // release armed and fired in one tick
        plan.push_back(plan_row(8'h02, 32'd71000, 1'b0, QUIET));
        plan.push_back(plan_row(8'h04, 32'd71001, 1'b1, fired(0, 0, 0, 1, 0, 1)));
        // click and long both due: click wins
        plan.push_back(plan_row(8'h02, 32'd72000, 1'b0, QUIET));
        plan.push_back(plan_row(8'h00, 32'd72005, 1'b1, fired(1, 0, 0, 0, 1, 0)));

        foreach (plan[r])
            push_sample(plan[r].keys, plan[r].at, plan[r].typed, plan[r].want);
        clock_ms = 32'd80000;

        // Random phases, each under its own slot setting
        for (phase = 0; phase < PHASES; phase++) begin
            drain_events();
            step_max = 60;
            for (i = 0; i < KEY_SLOTS; i++) begin
                case (phase)
                    1:       next_cfg[i] = '0;
                    2:       next_cfg[i] = '1;
                    default: next_cfg[i] = random_slot();
                endcase
            end
            if (phase == 2)
                step_max = 40000;
            program_slots();
            phase_start = beats_sent;
            while (beats_sent - phase_start < phase_items[phase]) begin
                if (phase != 1 && $urandom_range(0, 9) < 7)
                    run_gesture();
                else
                    run_noise();
            end
        end

        drain_events();
        faults += expected_events.size();
        if (faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
